FILE: rtl/multi_table_swap_remove_set_assert.svh
// assertion macros for the swap-remove set block
`ifndef MULTI_TABLE_SWAP_REMOVE_SET_ASSERT_SVH
`define MULTI_TABLE_SWAP_REMOVE_SET_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define MTSRS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("mtsrs: property failed");
`define MTSRS_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("mtsrs: reset property failed");
`else
`define MTSRS_ASSERT(lbl, prop)
`define MTSRS_ASSERT_RST(lbl, prop)
`endif

`endif

FILE: rtl/mtsrs_pkg.sv
// shared constants and codes for the swap-remove set block
package mtsrs_pkg;

  localparam int unsigned DefCapacity  = 64;
  localparam int unsigned DefNumTables = 9;

  localparam int unsigned OpW     = 2;
  localparam int unsigned TableW  = 4;
  localparam int unsigned RecW    = 15;
  localparam int unsigned StatusW = 2;
  localparam int unsigned CountW  = 7;
  localparam int unsigned SlotW   = 6;

  localparam logic [OpW-1:0] OpQuery  = 2'd0;
  localparam logic [OpW-1:0] OpInsert = 2'd1;
  localparam logic [OpW-1:0] OpDelete = 2'd2;

  localparam logic [StatusW-1:0] StOk       = 2'd0;
  localparam logic [StatusW-1:0] StFull     = 2'd1;
  localparam logic [StatusW-1:0] StNotFound = 2'd2;

endpackage

FILE: rtl/mtsrs_ram.sv
// generic simple dual-port ram with registered read
module mtsrs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/multi_table_swap_remove_set.sv
// top level: several dense record lists with append and swap-remove
//
//  channel | signals                                        | role
//  in      | in_valid_i/in_ready_o, opcode, table, record     | one operation
//  out     | out_valid_o/out_ready_i, status, count, slot     | one result per operation
//
// query, insert, bad table and refused operations go straight to the result state.
// a delete walks the list one entry read per cycle through the entry ram; a match
// reads the last entry and moves it into the matched slot, a miss gives not found.
// reset clears the list counts at once; entry memory needs no clearing.
// a new operation is taken while the previous result still waits at the output;
// a stalled output holds the block only once the next result is ready.
`include "multi_table_swap_remove_set_assert.svh"

module multi_table_swap_remove_set #(
  parameter int unsigned CAPACITY   = mtsrs_pkg::DefCapacity,
  parameter int unsigned NUM_TABLES = mtsrs_pkg::DefNumTables
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [mtsrs_pkg::OpW-1:0]     opcode_i,
  input  logic [mtsrs_pkg::TableW-1:0]  table_index_i,
  input  logic [mtsrs_pkg::RecW-1:0]    record_number_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [mtsrs_pkg::StatusW-1:0] status_o,
  output logic [mtsrs_pkg::CountW-1:0]  entry_count_o,
  output logic [mtsrs_pkg::SlotW-1:0]   slot_index_o
);
  import mtsrs_pkg::*;

  localparam int unsigned SW    = $clog2(CAPACITY);
  localparam int unsigned CW    = $clog2(CAPACITY + 1);
  localparam int unsigned DEPTH = NUM_TABLES * CAPACITY;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned TW    = (NUM_TABLES > 1) ? $clog2(NUM_TABLES) : 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_MVRD = 3'd2;
  localparam logic [2:0] S_MVWR = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  logic [2:0]         state_q, state_d;
  logic [RecW-1:0]    rec_q, rec_d;
  logic [TW-1:0]      tab_q, tab_d;
  logic [AW-1:0]      base_q, base_d;
  logic [CW-1:0]      cnt_q, cnt_d;
  logic [CW-1:0]      rd_idx_q, rd_idx_d;
  logic               cmp_vld_q, cmp_vld_d;
  logic [SW-1:0]      cmp_idx_q, cmp_idx_d;
  logic [SW-1:0]      hit_idx_q, hit_idx_d;
  logic [StatusW-1:0] res_status_q, res_status_d;
  logic [CW-1:0]      res_cnt_q, res_cnt_d;
  logic [SW-1:0]      res_slot_q, res_slot_d;
  logic [CW-1:0]      counts_q [NUM_TABLES];

  logic               out_valid_q, out_valid_d;
  logic [StatusW-1:0] status_q, status_d;
  logic [CountW-1:0]  entry_count_q, entry_count_d;
  logic [SlotW-1:0]   slot_q, slot_d;

  logic               accept;
  logic               tab_ok;
  logic [TW-1:0]      tab_sel;
  logic [CW-1:0]      cnt_in;
  logic [AW-1:0]      base_in;

  logic               cnt_we;
  logic [TW-1:0]      cnt_widx;
  logic [CW-1:0]      cnt_wval;

  logic               ram_we, ram_re;
  logic [AW-1:0]      ram_waddr, ram_raddr;
  logic [RecW-1:0]    ram_wdata, ram_rdata;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign tab_ok     = ({1'b0, table_index_i} < (TableW + 1)'(NUM_TABLES));
  assign tab_sel    = TW'(table_index_i);
  assign cnt_in     = tab_ok ? counts_q[tab_sel] : '0;
  assign base_in    = AW'(table_index_i) * AW'(CAPACITY);

  always_comb begin
    state_d      = state_q;
    rec_d        = rec_q;
    tab_d        = tab_q;
    base_d       = base_q;
    cnt_d        = cnt_q;
    rd_idx_d     = rd_idx_q;
    cmp_vld_d    = 1'b0;
    cmp_idx_d    = cmp_idx_q;
    hit_idx_d    = hit_idx_q;
    res_status_d = res_status_q;
    res_cnt_d    = res_cnt_q;
    res_slot_d   = res_slot_q;
    cnt_we       = 1'b0;
    cnt_widx     = tab_q;
    cnt_wval     = cnt_q - CW'(1);
    ram_we       = 1'b0;
    ram_waddr    = base_q + AW'(hit_idx_q);
    ram_wdata    = ram_rdata;
    ram_re       = 1'b0;
    ram_raddr    = base_q + AW'(rd_idx_q);
    out_valid_d   = out_valid_q && !out_ready_i;
    status_d      = status_q;
    entry_count_d = entry_count_q;
    slot_d        = slot_q;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          rec_d        = record_number_i;
          tab_d        = tab_sel;
          base_d       = base_in;
          cnt_d        = cnt_in;
          rd_idx_d     = '0;
          res_status_d = StOk;
          res_cnt_d    = cnt_in;
          res_slot_d   = '0;
          state_d      = S_FIN;
          if (!tab_ok) begin
            res_cnt_d = '0;
          end else if (opcode_i == OpInsert) begin
            if (cnt_in == CW'(CAPACITY)) begin
              res_status_d = StFull;
            end else begin
              ram_we     = 1'b1;
              ram_waddr  = base_in + AW'(cnt_in);
              ram_wdata  = record_number_i;
              cnt_we     = 1'b1;
              cnt_widx   = tab_sel;
              cnt_wval   = cnt_in + CW'(1);
              res_cnt_d  = cnt_in + CW'(1);
              res_slot_d = SW'(cnt_in);
            end
          end else if (opcode_i == OpDelete) begin
            if (cnt_in == '0) begin
              res_status_d = StNotFound;
            end else begin
              state_d = S_SCAN;
            end
          end
        end
      end
      S_SCAN: begin
        // one read issued per cycle, compare in the cycle after
        if (cmp_vld_q && (ram_rdata == rec_q)) begin
          hit_idx_d = cmp_idx_q;
          state_d   = S_MVRD;
        end else if (cmp_vld_q && (CW'(cmp_idx_q) == cnt_q - CW'(1))) begin
          res_status_d = StNotFound;
          state_d      = S_FIN;
        end else if (rd_idx_q < cnt_q) begin
          ram_re    = 1'b1;
          cmp_vld_d = 1'b1;
          cmp_idx_d = SW'(rd_idx_q);
          rd_idx_d  = rd_idx_q + CW'(1);
        end
      end
      S_MVRD: begin
        // fetch the last entry of the list
        ram_re    = 1'b1;
        ram_raddr = base_q + AW'(cnt_q - CW'(1));
        state_d   = S_MVWR;
      end
      S_MVWR: begin
        ram_we       = 1'b1;
        cnt_we       = 1'b1;
        res_status_d = StOk;
        res_cnt_d    = cnt_q - CW'(1);
        res_slot_d   = hit_idx_q;
        state_d      = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d   = 1'b1;
          status_d      = res_status_q;
          entry_count_d = CountW'(res_cnt_q);
          slot_d        = SlotW'(res_slot_q);
          state_d       = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  mtsrs_ram #(
    .WIDTH (RecW),
    .DEPTH (DEPTH)
  ) u_entries (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cmp_vld_q   <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NUM_TABLES; i++) begin
        counts_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      cmp_vld_q   <= cmp_vld_d;
      out_valid_q <= out_valid_d;
      if (cnt_we) begin
        counts_q[cnt_widx] <= cnt_wval;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rec_q         <= rec_d;
    tab_q         <= tab_d;
    base_q        <= base_d;
    cnt_q         <= cnt_d;
    rd_idx_q      <= rd_idx_d;
    cmp_idx_q     <= cmp_idx_d;
    hit_idx_q     <= hit_idx_d;
    res_status_q  <= res_status_d;
    res_cnt_q     <= res_cnt_d;
    res_slot_q    <= res_slot_d;
    status_q      <= status_d;
    entry_count_q <= entry_count_d;
    slot_q        <= slot_d;
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign entry_count_o = entry_count_q;
  assign slot_index_o  = slot_q;

  `MTSRS_ASSERT(a_scan_in_list, (state_q == S_SCAN && cmp_vld_q) |-> (CW'(cmp_idx_q) < cnt_q))
  `MTSRS_ASSERT(a_insert_room, (state_q == S_IDLE && ram_we) |-> (cnt_in < CW'(CAPACITY)))
  `MTSRS_ASSERT(a_move_follows_hit, (state_q == S_MVWR) |-> ($past(state_q) == S_MVRD))
  `MTSRS_ASSERT_RST(a_reset_idle, !rst_ni |=> (!out_valid_o && state_q == S_IDLE))

endmodule

FILE: verif/multi_table_swap_remove_set_checker.sv
`timescale 1ns / 100ps
// result checker for the swap-remove set: predicts each operation and compares results
module multi_table_swap_remove_set_checker #(
  parameter int unsigned CAPACITY   = mtsrs_pkg::DefCapacity,
  parameter int unsigned NUM_TABLES = mtsrs_pkg::DefNumTables
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_ready_i,
  input  logic [mtsrs_pkg::OpW-1:0]     opcode_i,
  input  logic [mtsrs_pkg::TableW-1:0]  table_index_i,
  input  logic [mtsrs_pkg::RecW-1:0]    record_number_i,
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  input  logic [mtsrs_pkg::StatusW-1:0] status_i,
  input  logic [mtsrs_pkg::CountW-1:0]  entry_count_i,
  input  logic [mtsrs_pkg::SlotW-1:0]   slot_index_i,
  output int unsigned                   fail_count_o,
  output int unsigned                   outstanding_o
);
  import mtsrs_pkg::*;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [CountW-1:0]  count;
    logic [SlotW-1:0]   slot;
  } op_result_t;

  logic [RecW-1:0] list_mem  [NUM_TABLES][CAPACITY];
  int unsigned     list_fill [NUM_TABLES];
  op_result_t      awaited_results [$];

  // applies one operation to the shadow lists and returns the result it must give
  function automatic op_result_t apply_list_op(logic [OpW-1:0] op, logic [TableW-1:0] tbl,
                                               logic [RecW-1:0] rec);
    op_result_t  res;
    int unsigned t;
    int unsigned n;
    int          hit;
    res.status = StOk;
    res.count  = '0;
    res.slot   = '0;
    hit        = -1;
    if (tbl >= NUM_TABLES) return res;
    t = tbl;
    n = list_fill[t];
    res.count = CountW'(n);
    if (op == OpInsert) begin
      if (n >= CAPACITY) begin
        res.status = StFull;
      end else begin
        list_mem[t][n] = rec;
        list_fill[t]   = n + 1;
        res.count      = CountW'(n + 1);
        res.slot       = SlotW'(n);
      end
    end else if (op == OpDelete) begin
      // lowest matching slot wins
      for (int i = 0; i < n; i++) begin
        if (hit < 0 && list_mem[t][i] == rec) hit = i;
      end
      if (hit < 0) begin
        res.status = StNotFound;
      end else begin
        list_mem[t][hit]   = list_mem[t][n-1];
        list_mem[t][n-1]   = '0;
        list_fill[t]       = n - 1;
        res.count          = CountW'(n - 1);
        res.slot           = SlotW'(hit);
      end
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    op_result_t want;
    if (!rst_ni) begin
      for (int t = 0; t < NUM_TABLES; t++) list_fill[t] = 0;
      awaited_results.delete();
      fail_count_o  = 0;
      outstanding_o = 0;
    end else begin
      // a result never comes in the cycle of its own transfer, so check before taking the new transfer
      if (out_valid_i && out_ready_i) begin
        if (awaited_results.size() == 0) begin
          $error("result transfer with nothing pending: status %0d count %0d slot %0d",
                 status_i, entry_count_i, slot_index_i);
          fail_count_o++;
        end else begin
          want = awaited_results.pop_front();
          if (status_i !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status_i);
            fail_count_o++;
          end
          if (entry_count_i !== want.count) begin
            $error("entry_count: expected %0d, got %0d", want.count, entry_count_i);
            fail_count_o++;
          end
          if (slot_index_i !== want.slot) begin
            $error("slot_index: expected %0d, got %0d", want.slot, slot_index_i);
            fail_count_o++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        awaited_results.push_back(apply_list_op(opcode_i, table_index_i, record_number_i));
      end
      outstanding_o = awaited_results.size();
    end
  end

endmodule

FILE: verif/multi_table_swap_remove_set_test.sv
`timescale 1ns / 100ps
// testbench top for the swap-remove set: clock, reset, operation stimulus and verdict
module multi_table_swap_remove_set_test;
  import mtsrs_pkg::*;

  localparam int unsigned NumTables   = DefNumTables;
  localparam int unsigned Capacity    = DefCapacity;
  localparam int unsigned ClkPeriod   = 12;
  localparam int unsigned RandomItems = 1300;
  localparam int unsigned DrainCycles = Capacity + 32;
  localparam int unsigned RunLimitNs  = 10_000_000;
  localparam int unsigned PoolSize    = 32;

  // opcode with no defined action, behaves as a count query
  localparam logic [OpW-1:0] OpSpare = 2'd3;

  typedef enum logic [1:0] {
    BurstFill,
    BurstDrain,
    BurstMixed
  } burst_mode_e;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [OpW-1:0]     opcode;
  logic [TableW-1:0]  table_index;
  logic [RecW-1:0]    record_number;
  logic               out_valid;
  logic               out_ready;
  logic [StatusW-1:0] status;
  logic [CountW-1:0]  entry_count;
  logic [SlotW-1:0]   slot_index;
  int unsigned        fail_count;
  int unsigned        outstanding;

  logic [RecW-1:0]    record_pool [PoolSize];

  always #(ClkPeriod / 2) clk = ~clk;

  multi_table_swap_remove_set u_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .opcode_i        (opcode),
    .table_index_i   (table_index),
    .record_number_i (record_number),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .status_o        (status),
    .entry_count_o   (entry_count),
    .slot_index_o    (slot_index)
  );

  multi_table_swap_remove_set_checker u_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_ready_i      (in_ready),
    .opcode_i        (opcode),
    .table_index_i   (table_index),
    .record_number_i (record_number),
    .out_valid_i     (out_valid),
    .out_ready_i     (out_ready),
    .status_i        (status),
    .entry_count_i   (entry_count),
    .slot_index_i    (slot_index),
    .fail_count_o    (fail_count),
    .outstanding_o   (outstanding)
  );

  function automatic int unsigned pick_gap(bit steady);
    int unsigned r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [OpW-1:0] pick_opcode(burst_mode_e mode);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 3) return OpSpare;
    if (r < 8) return OpQuery;
    case (mode)
      BurstFill:  return (r < 95) ? OpInsert : OpDelete;
      BurstDrain: return (r < 80) ? OpDelete : OpInsert;
      default:    return (r < 54) ? OpInsert : OpDelete;
    endcase
  endfunction

  // mostly pool records so deletes find their target, a few arbitrary ones that miss
  function automatic logic [RecW-1:0] pick_record();
    if ($urandom_range(0, 9) == 0) return RecW'($urandom_range(0, (1 << RecW) - 1));
    return record_pool[$urandom_range(0, PoolSize - 1)];
  endfunction

  // one operation transfer; valid stays high across back-to-back items
  task automatic issue(logic [OpW-1:0] op, logic [TableW-1:0] tbl, logic [RecW-1:0] rec,
                       bit steady);
    int unsigned gap;
    gap = pick_gap(steady);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    opcode        <= op;
    table_index   <= tbl;
    record_number <= rec;
    do @(posedge clk); while (!in_ready);
  endtask

  // receiver stalls: long ready stretches, short toggles and the odd long stall
  initial begin
    int unsigned hold;
    int unsigned r;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      r = $urandom_range(0, 99);
      if (r < 20) begin
        out_ready <= 1'b1;
        hold = $urandom_range(30, 120);
      end else if (r < 28) begin
        out_ready <= 1'b0;
        hold = $urandom_range(10, 40);
      end else begin
        out_ready <= ($urandom_range(0, 2) != 0);
        hold = $urandom_range(1, 3);
      end
      repeat (hold - 1) @(posedge clk);
    end
  end

  initial begin
    #(RunLimitNs);
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    burst_mode_e     mode;
    logic [TableW-1:0] hot_table;
    int unsigned     burst_len;
    int unsigned     sent;
    bit              steady;
    logic [OpW-1:0]  op;

    rst_n         = 1'b0;
    in_valid      = 1'b0;
    opcode        = OpQuery;
    table_index   = '0;
    record_number = '0;
    for (int i = 0; i < PoolSize; i++) record_pool[i] = RecW'($urandom_range(0, 32767));
    record_pool[0] = '0;
    record_pool[1] = '1;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty list, record zero, duplicates, swap-remove, misses, bad tables
    issue(OpQuery,  4'd0,  15'h0000, 1'b0);
    issue(OpDelete, 4'd0,  15'h0005, 1'b0);
    issue(OpInsert, 4'd0,  15'h0000, 1'b0);
    issue(OpInsert, 4'd0,  15'h7fff, 1'b0);
    issue(OpInsert, 4'd0,  15'h0000, 1'b0);
    issue(OpInsert, 4'd0,  15'h1234, 1'b0);
    issue(OpDelete, 4'd0,  15'h0000, 1'b0);
    issue(OpDelete, 4'd0,  15'h0000, 1'b0);
    issue(OpDelete, 4'd0,  15'h2aaa, 1'b0);
    issue(OpQuery,  4'd0,  15'h5555, 1'b0);
    issue(OpSpare,  4'd0,  15'h5555, 1'b0);
    issue(OpInsert, 4'd8,  15'h2aaa, 1'b0);
    issue(OpInsert, 4'd9,  15'h7fff, 1'b0);
    issue(OpInsert, 4'd15, 15'h7fff, 1'b0);
    issue(OpDelete, 4'd15, 15'h2aaa, 1'b0);
    issue(OpQuery,  4'd8,  15'h0000, 1'b0);
    issue(OpDelete, 4'd8,  15'h2aaa, 1'b0);
    for (int t = 1; t < 8; t++) issue(OpInsert, TableW'(t), 15'h5555, 1'b1);

    // random bursts on one table at a time; the first one fills a list past capacity
    sent      = 0;
    mode      = BurstFill;
    hot_table = TableW'($urandom_range(0, NumTables - 1));
    burst_len = 100;
    while (sent < RandomItems) begin
      steady = ($urandom_range(0, 4) == 0);
      repeat (burst_len) begin
        op = pick_opcode(mode);
        if ($urandom_range(0, 19) == 0) begin
          issue(op, TableW'($urandom_range(NumTables, (1 << TableW) - 1)), pick_record(),
                steady);
        end else begin
          issue(op, hot_table, pick_record(), steady);
          sent++;
        end
      end
      mode      = burst_mode_e'($urandom_range(0, 2));
      hot_table = TableW'($urandom_range(0, NumTables - 1));
      burst_len = $urandom_range(20, 100);
    end
    in_valid <= 1'b0;
    @(posedge clk);

    while (outstanding != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
